// ===== design/b58enc_pkg.sv =====
`default_nettype none

package b58enc_pkg;

    // Output alphabet, first character in the top byte
    localparam int unsigned ALPHA_LEN = 58;
    localparam logic [ALPHA_LEN*8-1:0] ALPHABET =
        "rpshnaf39wBUDNEGHJKLM4PQRST7VWXYZ2bcdeCg65jkm8oFqi1tuvAxyz";

    localparam logic [5:0] DIGIT_ZERO = 6'd0;
    localparam logic [5:0] DIGIT_MAX  = 6'd57;

    // Division by 58 of a 14-bit value: q = (x * 1130) >> 16 is exact below 58*256
    localparam logic [13:0]  RADIX       = 14'd58;
    localparam logic [10:0]  DIV58_RECIP = 11'd1130;
    localparam int unsigned  DIV58_SHIFT = 16;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CHECK,
        S_TEST,
        S_PASS_RD,
        S_PASS,
        S_FIN,
        S_EMIT_INIT,
        S_EMIT,
        S_DRD,
        S_DLD,
        S_ERR
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_byte;
        logic clear_str;
        logic div_init;
        logic pass_init;
        logic pass_step;
        logic pass_fin;
        logic emit_init;
        logic emit_zero;
        logic emit_dig;
        logic emit_err;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic ovf;
        logic start_lt_cnt;
        logic more;
        logic zero_left;
        logic last;
        logic slot_free;
    } status_t;

    // Digit to ASCII character
    function automatic logic [6:0] b58_char(input logic [5:0] digit);
        logic [5:0] d;
        logic [5:0] pos;
        d   = (digit > DIGIT_MAX) ? DIGIT_MAX : digit;
        pos = DIGIT_MAX - d;
        return ALPHABET[{pos, 3'b000} +: 7];
    endfunction

endpackage

`default_nettype wire

// ===== design/b58enc_dpath.sv =====
`default_nettype none

module b58enc_dpath #(
    parameter int MAX_BYTES  = 32,
    parameter int MAX_DIGITS = 44
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire b58enc_pkg::cmd_t    cmd,
    output b58enc_pkg::status_t      status,
    input  wire logic [7:0]          data_byte,
    input  wire logic                out_stall,
    output logic                     out_valid,
    output logic [6:0]               out_char,
    output logic                     final_char,
    output logic                     too_long
);

    localparam int BCNT_W = $clog2(MAX_BYTES + 1);
    localparam int BIDX_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int DCNT_W = $clog2(MAX_DIGITS + 1);
    localparam int DIDX_W = $clog2(MAX_DIGITS);
    localparam int SUM_W  = ((BCNT_W > DCNT_W) ? BCNT_W : DCNT_W) + 1;

    // Byte store and its read port
    logic [7:0]        byte_mem_reg [MAX_BYTES];
    logic [7:0]        brd_data_reg;
    logic [BCNT_W-1:0] byte_cnt_reg;
    logic [BCNT_W-1:0] lz_cnt_reg;
    logic              leading_reg;
    logic              ovf_reg;

    // Division pass
    logic [BCNT_W-1:0] start_reg;
    logic [BCNT_W-1:0] idx_reg;
    logic [BCNT_W-1:0] widx_reg;
    logic [BCNT_W-1:0] new_start_reg;
    logic              nz_seen_reg;
    logic [5:0]        rem_reg;

    // Digit store and emission
    logic [5:0]        digit_mem_reg [MAX_DIGITS];
    logic [5:0]        drd_data_reg;
    logic [DCNT_W-1:0] dig_cnt_reg;
    logic [DCNT_W-1:0] emit_left_reg;
    logic [BCNT_W-1:0] zero_left_reg;
    logic [DIDX_W-1:0] dig_idx_reg;

    // Output register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [6:0]        out_char_reg;
    logic              final_char_reg;
    logic              too_long_reg;

    logic              byte_room;
    logic              digit_room;
    logic [BCNT_W-1:0] rd_addr;
    logic [13:0]       cur;
    logic [24:0]       prod;
    logic [7:0]        quot;
    logic [13:0]       rem_full;
    logic [SUM_W-1:0]  total_sum;
    logic [SUM_W-1:0]  total_cap;
    logic [DCNT_W-1:0] dig_top;
    logic              load_out;

    // One step of the long division: {rem, byte} / 58
    assign cur      = {rem_reg, brd_data_reg};
    assign prod     = 25'(cur) * 25'(b58enc_pkg::DIV58_RECIP);
    assign quot     = prod[b58enc_pkg::DIV58_SHIFT +: 8];
    assign rem_full = cur - 14'(quot) * b58enc_pkg::RADIX;

    assign byte_room  = byte_cnt_reg < BCNT_W'(MAX_BYTES);
    assign digit_room = dig_cnt_reg < DCNT_W'(MAX_DIGITS);
    assign rd_addr    = cmd.pass_init ? start_reg : idx_reg;

    // Characters to send, capped at the digit store size
    assign total_sum = SUM_W'(lz_cnt_reg) + SUM_W'(dig_cnt_reg);
    assign total_cap = (total_sum > SUM_W'(MAX_DIGITS)) ? SUM_W'(MAX_DIGITS) : total_sum;
    assign dig_top   = dig_cnt_reg - DCNT_W'(1);

    assign load_out = cmd.emit_zero | cmd.emit_dig | cmd.emit_err;

    always_comb
    begin
        status.ovf          = ovf_reg;
        status.start_lt_cnt = start_reg < byte_cnt_reg;
        status.more         = idx_reg < byte_cnt_reg;
        status.zero_left    = zero_left_reg != '0;
        status.last         = emit_left_reg == DCNT_W'(1);
        status.slot_free    = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Memories
    always_ff @(posedge clk)
    begin
        if (cmd.load_byte && byte_room)
            byte_mem_reg[byte_cnt_reg[BIDX_W-1:0]] <= data_byte;
        else if (cmd.pass_step)
            byte_mem_reg[widx_reg[BIDX_W-1:0]] <= quot;
        brd_data_reg <= byte_mem_reg[rd_addr[BIDX_W-1:0]];

        if (cmd.pass_fin && digit_room)
            digit_mem_reg[dig_cnt_reg[DIDX_W-1:0]] <= rem_reg;
        drd_data_reg <= digit_mem_reg[dig_idx_reg];
    end

    // String state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_cnt_reg  <= '0;
            lz_cnt_reg    <= '0;
            leading_reg   <= 1'b1;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_str)
            begin
                byte_cnt_reg <= '0;
                lz_cnt_reg   <= '0;
                leading_reg  <= 1'b1;
                ovf_reg      <= 1'b0;
            end
            else if (cmd.load_byte)
            begin
                if (byte_room)
                begin
                    byte_cnt_reg <= byte_cnt_reg + BCNT_W'(1);
                    if (leading_reg)
                    begin
                        if (data_byte == 8'd0)
                            lz_cnt_reg <= lz_cnt_reg + BCNT_W'(1);
                        else
                            leading_reg <= 1'b0;
                    end
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Division and emission working registers, set before each use
    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            start_reg   <= lz_cnt_reg;
            dig_cnt_reg <= '0;
        end
        else if (cmd.pass_fin)
        begin
            start_reg <= new_start_reg;
            if (digit_room)
                dig_cnt_reg <= dig_cnt_reg + DCNT_W'(1);
        end

        if (cmd.pass_init)
        begin
            idx_reg       <= start_reg + BCNT_W'(1);
            widx_reg      <= start_reg;
            rem_reg       <= '0;
            nz_seen_reg   <= 1'b0;
            new_start_reg <= byte_cnt_reg;
        end
        else if (cmd.pass_step)
        begin
            rem_reg <= rem_full[5:0];
            // first nonzero quotient byte starts the next pass
            if (quot != 8'd0 && !nz_seen_reg)
            begin
                nz_seen_reg   <= 1'b1;
                new_start_reg <= widx_reg;
            end
            if (status.more)
            begin
                idx_reg  <= idx_reg + BCNT_W'(1);
                widx_reg <= idx_reg;
            end
        end

        if (cmd.emit_init)
        begin
            emit_left_reg <= DCNT_W'(total_cap);
            zero_left_reg <= lz_cnt_reg;
            dig_idx_reg   <= dig_top[DIDX_W-1:0];
        end
        else if (cmd.emit_zero)
        begin
            emit_left_reg <= emit_left_reg - DCNT_W'(1);
            zero_left_reg <= zero_left_reg - BCNT_W'(1);
        end
        else if (cmd.emit_dig)
        begin
            emit_left_reg <= emit_left_reg - DCNT_W'(1);
            dig_idx_reg   <= dig_idx_reg - DIDX_W'(1);
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_err)
        begin
            out_char_reg   <= 7'd0;
            final_char_reg <= 1'b0;
            too_long_reg   <= 1'b1;
        end
        else if (cmd.emit_zero)
        begin
            out_char_reg   <= b58enc_pkg::b58_char(b58enc_pkg::DIGIT_ZERO);
            final_char_reg <= status.last;
            too_long_reg   <= 1'b0;
        end
        else if (cmd.emit_dig)
        begin
            out_char_reg   <= b58enc_pkg::b58_char(drd_data_reg);
            final_char_reg <= status.last;
            too_long_reg   <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign final_char = final_char_reg;
    assign too_long   = too_long_reg;

endmodule

`default_nettype wire

// ===== design/b58enc_ctrl.sv =====
`default_nettype none

module b58enc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                final_byte,
    input  wire b58enc_pkg::status_t status,
    output b58enc_pkg::cmd_t         cmd,
    output logic                     in_stall
);

    b58enc_pkg::state_t state_reg;
    b58enc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= b58enc_pkg::S_LOAD;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            b58enc_pkg::S_LOAD:
                if (in_valid && final_byte)
                    state_next = b58enc_pkg::S_CHECK;
            b58enc_pkg::S_CHECK:
                state_next = status.ovf ? b58enc_pkg::S_ERR : b58enc_pkg::S_TEST;
            b58enc_pkg::S_TEST:
                state_next = status.start_lt_cnt ? b58enc_pkg::S_PASS_RD
                                                 : b58enc_pkg::S_EMIT_INIT;
            b58enc_pkg::S_PASS_RD:
                state_next = b58enc_pkg::S_PASS;
            b58enc_pkg::S_PASS:
                if (!status.more)
                    state_next = b58enc_pkg::S_FIN;
            b58enc_pkg::S_FIN:
                state_next = b58enc_pkg::S_TEST;
            b58enc_pkg::S_EMIT_INIT:
                state_next = b58enc_pkg::S_EMIT;
            b58enc_pkg::S_EMIT:
                if (!status.zero_left)
                    state_next = b58enc_pkg::S_DRD;
                else if (status.slot_free && status.last)
                    state_next = b58enc_pkg::S_LOAD;
            b58enc_pkg::S_DRD:
                state_next = b58enc_pkg::S_DLD;
            b58enc_pkg::S_DLD:
                if (status.slot_free)
                    state_next = status.last ? b58enc_pkg::S_LOAD : b58enc_pkg::S_DRD;
            b58enc_pkg::S_ERR:
                if (status.slot_free)
                    state_next = b58enc_pkg::S_LOAD;
            default:
                state_next = b58enc_pkg::S_LOAD;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            b58enc_pkg::S_LOAD:
            begin
                in_stall      = 1'b0;
                cmd.load_byte = in_valid;
            end
            b58enc_pkg::S_CHECK:
                cmd.div_init = !status.ovf;
            b58enc_pkg::S_TEST:
                ;
            b58enc_pkg::S_PASS_RD:
                cmd.pass_init = 1'b1;
            b58enc_pkg::S_PASS:
                cmd.pass_step = 1'b1;
            b58enc_pkg::S_FIN:
                cmd.pass_fin = 1'b1;
            b58enc_pkg::S_EMIT_INIT:
                cmd.emit_init = 1'b1;
            b58enc_pkg::S_EMIT:
            begin
                cmd.emit_zero = status.zero_left && status.slot_free;
                cmd.clear_str = status.zero_left && status.slot_free && status.last;
            end
            b58enc_pkg::S_DRD:
                ;
            b58enc_pkg::S_DLD:
            begin
                cmd.emit_dig  = status.slot_free;
                cmd.clear_str = status.slot_free && status.last;
            end
            b58enc_pkg::S_ERR:
            begin
                cmd.emit_err  = status.slot_free;
                cmd.clear_str = status.slot_free;
            end
            default:
                ;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/base58_byte_encoder_unit.sv =====
// Base58 encoder for a big-endian byte string.
// Input channel: data_byte/final_byte with in_valid/in_stall, one byte per item,
// most significant byte first; final_byte marks the last byte of a string.
// Output channel: out_char/final_char/too_long with out_valid/out_stall, one
// character per item, leading zero bytes first as 'r', then the digits most
// significant first; final_char marks the last character. A string longer than
// MAX_BYTES gives a single item with too_long set and no characters.
// Timing: bytes are taken one per cycle while the string is loading. After the
// final byte the input stalls while the number is divided by 58 repeatedly:
// each digit costs one pass over the stored bytes from the first nonzero one
// on, in states S_PASS_RD, S_PASS and S_FIN. The pass rate is set by the byte
// store, one byte read and one written back per cycle. After a setup state
// (S_EMIT_INIT) each leading 'r' is loaded from S_EMIT, and each digit is read
// from the digit store in S_DRD and loaded in S_DLD.
// The input reopens once the last character sits in the output register.
// Reset clears the string and empties the output register; the stores need
// no clearing. A stalled output item holds its value and pauses emission.
`default_nettype none

module base58_byte_encoder_unit #(
    parameter int MAX_BYTES  = 32,
    parameter int MAX_DIGITS = 44
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       final_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [6:0]      out_char,
    output logic            final_char,
    output logic            too_long
);

    b58enc_pkg::cmd_t    cmd;
    b58enc_pkg::status_t status;

    b58enc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .final_byte (final_byte),
        .status     (status),
        .cmd        (cmd),
        .in_stall   (in_stall)
    );

    b58enc_dpath #(
        .MAX_BYTES  (MAX_BYTES),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .data_byte  (data_byte),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_char   (out_char),
        .final_char (final_char),
        .too_long   (too_long)
    );

`ifndef SYNTHESIS
    // Error item carries no character and no final mark
    a_err_item: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && too_long) |-> (!final_char && out_char == 7'd0))
        else $error("error item with character data");

    // Input closes right after a final byte is taken
    a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && final_byte) |=> in_stall)
        else $error("input open after final byte");

    // No input accepted during a division pass
    a_pass_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pass_step || cmd.pass_init || cmd.pass_fin) |-> in_stall)
        else $error("input open during division");

    // At most one output load source at a time
    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.emit_zero, cmd.emit_dig, cmd.emit_err}))
        else $error("conflicting output loads");
`endif

endmodule

`default_nettype wire

// ===== verif/b58_stream_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the base58 encoder, predicts the characters of
// each string from the accepted bytes and compares every output item.
module b58_stream_checker #(
    parameter int MAX_BYTES  = 32,
    parameter int MAX_DIGITS = 44
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       final_byte,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [6:0] out_char,
    input  wire logic       final_char,
    input  wire logic       too_long,
    output int              mismatches,
    output int              chars_waiting,
    output int              strings_encoded,
    output int              strings_rejected
);

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
        logic       err;
    } enc_char_t;

    string digit_chars = "rpshnaf39wBUDNEGHJKLM4PQRST7VWXYZ2bcdeCg65jkm8oFqi1tuvAxyz";

    enc_char_t   expected_chars[$];

    // Current string as seen on the input channel
    logic [7:0]  num_bytes [0:MAX_BYTES-1];
    int unsigned num_len;
    bit          spilled;
    int unsigned lead_zeros;
    bit          in_lead;

    task automatic flag_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Repeated division by 58 of the stored number; queue the characters
    task automatic encode_string();
        logic [7:0]  work [0:MAX_BYTES-1];
        logic [5:0]  digits [0:MAX_DIGITS-1];
        int unsigned rem;
        int unsigned cur;
        int unsigned start;
        int unsigned ndig;
        int unsigned total;
        int unsigned n;
        int unsigned k;
        int unsigned i;
        byte         c;
        enc_char_t   e;
        work  = num_bytes;
        start = lead_zeros;
        ndig  = 0;
        while (start < num_len)
        begin
            rem = 0;
            for (i = start; i < num_len; i++)
            begin
                cur     = rem * 256 + work[i];
                work[i] = 8'(cur / 58);
                rem     = cur % 58;
            end
            if (ndig < MAX_DIGITS)
            begin
                digits[ndig] = rem[5:0];
                ndig++;
            end
            while (start < num_len && work[start] == 8'h00)
                start++;
        end
        total = lead_zeros + ndig;
        if (total > MAX_DIGITS)
            total = MAX_DIGITS;
        n = 0;
        // one 'r' per leading zero byte
        for (k = 0; k < lead_zeros && n < total; k++)
        begin
            c      = digit_chars[0];
            e.ch   = c[6:0];
            e.last = (n == total - 1);
            e.err  = 1'b0;
            expected_chars.push_back(e);
            n++;
        end
        // digits, most significant first
        for (k = ndig; k > 0 && n < total; k--)
        begin
            c      = digit_chars[digits[k-1]];
            e.ch   = c[6:0];
            e.last = (n == total - 1);
            e.err  = 1'b0;
            expected_chars.push_back(e);
            n++;
        end
    endtask

    task automatic take_byte(input logic [7:0] b, input logic last);
        enc_char_t e;
        if (num_len < MAX_BYTES)
        begin
            num_bytes[num_len] = b;
            num_len++;
            if (in_lead)
            begin
                if (b == 8'h00)
                    lead_zeros++;
                else
                    in_lead = 1'b0;
            end
        end
        else
            spilled = 1'b1;

        if (last)
        begin
            if (spilled)
            begin
                e.ch   = 7'd0;
                e.last = 1'b0;
                e.err  = 1'b1;
                expected_chars.push_back(e);
                strings_rejected++;
            end
            else
            begin
                encode_string();
                strings_encoded++;
            end
            num_len    = 0;
            spilled    = 1'b0;
            lead_zeros = 0;
            in_lead    = 1'b1;
        end
    endtask

    task automatic check_char();
        enc_char_t e;
        if (expected_chars.size() == 0)
        begin
            flag_mismatch($sformatf("unexpected item char=%02h final=%b too_long=%b",
                                    out_char, final_char, too_long));
            return;
        end
        e = expected_chars.pop_front();
        if (out_char !== e.ch)
            flag_mismatch($sformatf("out_char %02h, expected %02h", out_char, e.ch));
        if (final_char !== e.last)
            flag_mismatch($sformatf("final_char %b, expected %b", final_char, e.last));
        if (too_long !== e.err)
            flag_mismatch($sformatf("too_long %b, expected %b", too_long, e.err));
    endtask

    // Output first: an item leaving now never stems from a byte taken at this edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_chars.delete();
            num_len          = 0;
            spilled          = 1'b0;
            lead_zeros       = 0;
            in_lead          = 1'b1;
            mismatches       = 0;
            chars_waiting    = 0;
            strings_encoded  = 0;
            strings_rejected = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_char();
            if (in_valid && !in_stall)
                take_byte(data_byte, final_byte);
            chars_waiting = expected_chars.size();
        end
    end

endmodule

// ===== verif/base58_byte_encoder_unit_tb.sv =====
`timescale 1ns / 100ps

module base58_byte_encoder_unit_tb;

    localparam int MAX_BYTES      = 32;
    localparam int MAX_DIGITS     = 44;
    localparam int ITEM_TARGET    = 250;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 100;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] data_byte;
    logic       final_byte;
    logic       out_valid;
    logic       out_stall;
    logic [6:0] out_char;
    logic       final_char;
    logic       too_long;

    int mismatches;
    int chars_waiting;
    int strings_encoded;
    int strings_rejected;

    int cycles     = 0;
    int items_sent = 0;
    bit quiet;
    bit hold_go;
    bit hold_on;

    logic [7:0] string_bytes[$];

    base58_byte_encoder_unit #(
        .MAX_BYTES (MAX_BYTES),
        .MAX_DIGITS(MAX_DIGITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .final_byte(final_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .final_char(final_char),
        .too_long  (too_long)
    );

    b58_stream_checker #(
        .MAX_BYTES (MAX_BYTES),
        .MAX_DIGITS(MAX_DIGITS)
    ) enc_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .final_byte      (final_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_char        (out_char),
        .final_char      (final_char),
        .too_long        (too_long),
        .mismatches      (mismatches),
        .chars_waiting   (chars_waiting),
        .strings_encoded (strings_encoded),
        .strings_rejected(strings_rejected)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d items sent", cycles, items_sent);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver pacing: random stalls, none while quiet, solid during hold-off
    always @(negedge clk)
    begin : rx_pace
        bit s;
        if (hold_on)
            s = 1'b1;
        else if (quiet)
            s = 1'b0;
        else
            s = ($urandom_range(0, 99) < 13);
        out_stall <= s;
    end

    // Long receiver hold-off so the encoder backs up onto its input
    initial
    begin : holdoff
        hold_on = 1'b0;
        wait (hold_go);
        @(posedge clk);
        hold_on = 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        hold_on = 1'b0;
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        // drop in_valid before some items, except while quiet
        if (!quiet && $urandom_range(0, 99) < 15)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        final_byte <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_string();
        int i;
        for (i = 0; i < string_bytes.size(); i++)
            send_byte(string_bytes[i], i == string_bytes.size() - 1);
    endtask

    // len bytes, the first zeros of them zero, the rest random with extremes mixed in
    task automatic build_string(input int len, input int zeros);
        int i;
        int r;
        string_bytes.delete();
        for (i = 0; i < len; i++)
        begin
            r = $urandom_range(0, 9);
            if (i < zeros || r == 1)
                string_bytes.push_back(8'h00);
            else if (r == 0)
                string_bytes.push_back(8'hFF);
            else
                string_bytes.push_back(8'($urandom_range(1, 255)));
        end
    endtask

    initial
    begin : stimulus
        int i;
        int r;
        int len;
        int zeros;
        int strings;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        data_byte  = 8'h00;
        final_byte = 1'b0;
        quiet      = 1'b0;
        hold_go    = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed strings: single zero, single 0xFF, all-zero string,
        // leading zeros before a one, value 58, largest digit, bit patterns,
        // trailing zeros
        string_bytes = '{8'h00};
        send_string();
        string_bytes = '{8'hFF};
        send_string();
        string_bytes = '{8'h00, 8'h00, 8'h00};
        send_string();
        string_bytes = '{8'h00, 8'h00, 8'h01};
        send_string();
        string_bytes = '{8'h00, 8'h3A};
        send_string();
        string_bytes = '{8'h39};
        send_string();
        string_bytes = '{8'hAA, 8'h55, 8'h0F, 8'hF0};
        send_string();
        string_bytes = '{8'h01, 8'h00, 8'h00};
        send_string();

        // Random strings, mostly short; a few at or past the byte limit
        strings = 0;
        while (items_sent < ITEM_TARGET)
        begin
            quiet <= (strings >= 10 && strings < 16);
            if (strings == 2)
                hold_go <= 1'b1;
            case (strings)
                0:
                begin
                    string_bytes.delete();
                    for (i = 0; i < MAX_BYTES; i++)
                        string_bytes.push_back(8'hFF);
                end
                1:
                    build_string(MAX_BYTES, MAX_BYTES);
                3:
                    build_string(MAX_BYTES + 1, 0);
                default:
                begin
                    r = $urandom_range(0, 99);
                    if (r < 65)
                        len = $urandom_range(1, 6);
                    else if (r < 85)
                        len = $urandom_range(7, MAX_BYTES - 1);
                    else if (r < 93)
                        len = MAX_BYTES;
                    else
                        len = $urandom_range(MAX_BYTES + 1, MAX_BYTES + 8);
                    zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len) : 0;
                    build_string(len, zeros);
                end
            endcase
            send_string();
            strings++;
        end
        in_valid <= 1'b0;

        wait (chars_waiting == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d bytes in %0d strings over %0d cycles,",
                 items_sent, strings + 8, cycles);
        $display("with a %0d-cycle output hold-off; encoded: %0d, rejected as too long: %0d",
                 HOLDOFF_CYCLES, strings_encoded, strings_rejected);
        if (mismatches == 0 && chars_waiting == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/b58enc_pkg.sv
design/b58enc_dpath.sv
design/b58enc_ctrl.sv
design/base58_byte_encoder_unit.sv
verif/b58_stream_checker.sv
verif/base58_byte_encoder_unit_tb.sv
